FILE: src/ppds_pkg.sv
`default_nettype none

package ppds_pkg;

    localparam int MAX_CASES   = 256;
    localparam int COORD_W     = 20;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int ABS_W       = COORD_W;
    localparam int SS_W        = 2 * ABS_W + 2;
    localparam int D_W         = 22;
    localparam int V_W         = 2 * D_W;
    localparam int ADDR_W      = $clog2(MAX_CASES);
    localparam int CNT_W       = $clog2(MAX_CASES + 1);
    localparam int SUM_W       = D_W + ADDR_W;
    localparam int ACC_W       = V_W + ADDR_W;
    localparam int DIV_STEP_W  = $clog2(ACC_W + 1);
    localparam int ROOT_STEP_W = $clog2(D_W + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic                      last_case;
    } t_in;

    typedef struct packed {
        logic [D_W-1:0] distance;
        logic           stats_valid;
        logic [D_W-1:0] mean_distance;
        logic [V_W-1:0] variance;
        logic [D_W-1:0] std_deviation;
        logic           overflow;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_DROOT_GO,
        ST_DROOT,
        ST_STORE,
        ST_MEAN_GO,
        ST_MEAN,
        ST_WALK,
        ST_VDIV_GO,
        ST_VDIV,
        ST_VROOT_GO,
        ST_VROOT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/ppds_in_if.sv
`default_nettype none

interface ppds_in_if;
    logic           valid;
    logic           ready;
    ppds_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ppds_out_if.sv
`default_nettype none

interface ppds_out_if;
    logic           valid;
    logic           ready;
    ppds_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/point_pair_distance_statistics.sv
// Channel  Direction  Contents
// i_in     sink       two 3-D points in signed Q12.8 and the last-case flag
// o_out    source     distance, statistics on a last case, overflow flag
//
// A case that is not last is paced by the 22-step square root. A last case adds two
// 52-step divisions, one pass over the distance memory at one read a cycle, and a
// second square root. Reset clears the case count, the running sum and the overflow
// flag; the memory is not cleared. A stalled output holds its result, and the next
// case is taken while that result waits.
`default_nettype none

module point_pair_distance_statistics (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppds_in_if.sink     i_in,
    ppds_out_if.source  o_out
);

    ppds_pkg::t_state                 r_state;
    ppds_pkg::t_state                 n_state;
    ppds_pkg::t_in                    r_in;
    ppds_pkg::t_out                   r_out;
    logic                             r_out_vld;

    logic [1:0]                       r_sq_step;
    logic [2*ppds_pkg::ABS_W-1:0]     r_prod;
    logic [ppds_pkg::SS_W-1:0]        r_ss;
    logic [ppds_pkg::D_W-1:0]         r_dist;
    logic [ppds_pkg::D_W-1:0]         r_mean;
    logic [ppds_pkg::V_W-1:0]         r_var;
    logic [ppds_pkg::CNT_W-1:0]       r_count;
    logic [ppds_pkg::CNT_W-1:0]       r_idx;
    logic [ppds_pkg::SUM_W-1:0]       r_sum;
    logic                             r_ovf;

    logic [ppds_pkg::D_W-1:0]         mem [ppds_pkg::MAX_CASES];
    logic [ppds_pkg::D_W-1:0]         r_rd_data;
    logic                             r_rd_vld;
    logic [ppds_pkg::V_W-1:0]         r_dev_sq;
    logic                             r_dev_vld;
    logic [ppds_pkg::ACC_W-1:0]       r_acc;

    logic                             in_ready;
    logic                             root_start;
    logic                             div_start;
    logic                             mem_we;
    logic                             rd_en;
    logic                             out_load;
    logic                             room;

    logic [ppds_pkg::COORD_W-1:0]     sel_a;
    logic [ppds_pkg::COORD_W-1:0]     sel_b;
    logic [ppds_pkg::DIFF_W-1:0]      diff;
    logic [ppds_pkg::DIFF_W-1:0]      neg_diff;
    logic [ppds_pkg::ABS_W-1:0]       sq_abs;
    logic [ppds_pkg::D_W-1:0]         dev_abs;

    logic [ppds_pkg::V_W-1:0]         radicand;
    logic                             root_done;
    logic [ppds_pkg::D_W-1:0]         root;
    logic [ppds_pkg::ACC_W-1:0]       dividend;
    logic                             div_done;
    logic [ppds_pkg::ACC_W-1:0]       quotient;

    assign room = (r_count < ppds_pkg::CNT_W'(ppds_pkg::MAX_CASES));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppds_pkg::ST_IDLE:     if (i_in.valid) n_state = ppds_pkg::ST_SQ;
            ppds_pkg::ST_SQ:       if (r_sq_step == 2'd3) n_state = ppds_pkg::ST_DROOT_GO;
            ppds_pkg::ST_DROOT_GO: n_state = ppds_pkg::ST_DROOT;
            ppds_pkg::ST_DROOT:    if (root_done) n_state = ppds_pkg::ST_STORE;
            ppds_pkg::ST_STORE: begin
                n_state = r_in.last_case ? ppds_pkg::ST_MEAN_GO : ppds_pkg::ST_OUT;
            end
            ppds_pkg::ST_MEAN_GO:  n_state = ppds_pkg::ST_MEAN;
            ppds_pkg::ST_MEAN:     if (div_done) n_state = ppds_pkg::ST_WALK;
            ppds_pkg::ST_WALK: begin
                if (r_idx == r_count && !r_rd_vld && !r_dev_vld) begin
                    n_state = ppds_pkg::ST_VDIV_GO;
                end
            end
            ppds_pkg::ST_VDIV_GO:  n_state = ppds_pkg::ST_VDIV;
            ppds_pkg::ST_VDIV:     if (div_done) n_state = ppds_pkg::ST_VROOT_GO;
            ppds_pkg::ST_VROOT_GO: n_state = ppds_pkg::ST_VROOT;
            ppds_pkg::ST_VROOT:    if (root_done) n_state = ppds_pkg::ST_OUT;
            ppds_pkg::ST_OUT:      if (out_load) n_state = ppds_pkg::ST_IDLE;
            default:               n_state = ppds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = (r_state == ppds_pkg::ST_IDLE);
        root_start = (r_state == ppds_pkg::ST_DROOT_GO) || (r_state == ppds_pkg::ST_VROOT_GO);
        div_start  = (r_state == ppds_pkg::ST_MEAN_GO) || (r_state == ppds_pkg::ST_VDIV_GO);
        mem_we     = (r_state == ppds_pkg::ST_STORE) && room;
        rd_en      = (r_state == ppds_pkg::ST_WALK) && (r_idx != r_count);
        out_load   = (r_state == ppds_pkg::ST_OUT) && (!r_out_vld || o_out.ready);
        radicand   = (r_state == ppds_pkg::ST_VROOT_GO) ? r_var
                                                        : ppds_pkg::V_W'(r_ss);
        dividend   = (r_state == ppds_pkg::ST_VDIV_GO) ? r_acc
                                                       : ppds_pkg::ACC_W'(r_sum);
    end

    always_comb begin
        case (r_sq_step)
            2'd0: begin
                sel_a = r_in.first_x;
                sel_b = r_in.second_x;
            end
            2'd1: begin
                sel_a = r_in.first_y;
                sel_b = r_in.second_y;
            end
            default: begin
                sel_a = r_in.first_z;
                sel_b = r_in.second_z;
            end
        endcase
        diff     = {sel_a[ppds_pkg::COORD_W-1], sel_a} - {sel_b[ppds_pkg::COORD_W-1], sel_b};
        neg_diff = '0 - diff;
        sq_abs   = diff[ppds_pkg::DIFF_W-1] ? neg_diff[ppds_pkg::ABS_W-1:0]
                                            : diff[ppds_pkg::ABS_W-1:0];
        dev_abs  = (r_rd_data >= r_mean) ? (r_rd_data - r_mean) : (r_mean - r_rd_data);
    end

    ppds_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root)
    );

    ppds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[ppds_pkg::ADDR_W-1:0]] <= r_dist;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[ppds_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (r_state == ppds_pkg::ST_SQ) begin
            if (r_sq_step != 2'd3) begin
                r_prod <= sq_abs * sq_abs;
            end
            if (r_sq_step != 2'd0) begin
                r_ss <= r_ss + ppds_pkg::SS_W'(r_prod);
            end
        end else if (in_ready) begin
            r_ss <= '0;
        end
        if (r_state == ppds_pkg::ST_DROOT && root_done) begin
            r_dist <= root;
        end
        if (r_state == ppds_pkg::ST_MEAN && div_done) begin
            r_mean <= quotient[ppds_pkg::D_W-1:0];
        end
        if (r_state == ppds_pkg::ST_VDIV && div_done) begin
            r_var <= quotient[ppds_pkg::V_W-1:0];
        end
        if (r_rd_vld) begin
            r_dev_sq <= dev_abs * dev_abs;
        end
        if (r_state == ppds_pkg::ST_MEAN_GO) begin
            r_acc <= '0;
            r_idx <= '0;
        end else begin
            if (r_dev_vld) begin
                r_acc <= r_acc + ppds_pkg::ACC_W'(r_dev_sq);
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (out_load) begin
            r_out.distance      <= r_dist;
            r_out.stats_valid   <= r_in.last_case;
            r_out.mean_distance <= r_in.last_case ? r_mean : '0;
            r_out.variance      <= r_in.last_case ? r_var : '0;
            r_out.std_deviation <= r_in.last_case ? root : '0;
            r_out.overflow      <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppds_pkg::ST_IDLE;
            r_sq_step <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_dev_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            r_dev_vld <= r_rd_vld;
            if (r_state == ppds_pkg::ST_SQ) begin
                r_sq_step <= r_sq_step + 1'b1;
            end else begin
                r_sq_step <= '0;
            end
            if (r_state == ppds_pkg::ST_STORE) begin
                if (room) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + ppds_pkg::SUM_W'(r_dist);
                end else begin
                    r_ovf   <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
                if (r_in.last_case) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppds_pkg::CNT_W'(ppds_pkg::MAX_CASES))
        else $error("Case count exceeds the store depth.");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppds_pkg::ST_WALK) |-> (r_idx <= r_count))
        else $error("Store walk ran past the case count.");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_in.last_case) |=> (r_count == '0 && r_sum == '0 && !r_ovf))
        else $error("State not cleared after a last case.");

    a_var_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppds_pkg::ST_VDIV && div_done)
            |-> (quotient[ppds_pkg::ACC_W-1:ppds_pkg::V_W] == '0))
        else $error("Variance quotient does not fit its field.");

    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.stats_valid)
            |-> (r_out.mean_distance == '0 && r_out.variance == '0
                 && r_out.std_deviation == '0))
        else $error("Statistics fields set on a transaction that is not a last case.");

endmodule

`default_nettype wire

FILE: src/ppds_sqrt.sv
`default_nettype none

module ppds_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [ppds_pkg::V_W-1:0] i_radicand,
    output logic                          o_done,
    output logic [ppds_pkg::D_W-1:0]      o_root
);

    logic                              r_busy;
    logic                              r_done;
    logic [ppds_pkg::ROOT_STEP_W-1:0]  r_step;
    logic [ppds_pkg::V_W-1:0]          r_val;
    logic [ppds_pkg::D_W+1:0]          r_rem;
    logic [ppds_pkg::D_W-1:0]          r_root;

    logic [ppds_pkg::D_W+3:0]          cand;
    logic [ppds_pkg::D_W+3:0]          trial;
    logic [ppds_pkg::D_W+3:0]          cand_sub;
    logic                              ge;
    logic [ppds_pkg::D_W+1:0]          n_rem;
    logic [ppds_pkg::D_W-1:0]          n_root;

    always_comb begin
        cand     = {r_rem, r_val[ppds_pkg::V_W-1 -: 2]};
        trial    = {2'b00, r_root, 2'b01};
        ge       = (cand >= trial);
        cand_sub = cand - trial;
        n_rem    = ge ? cand_sub[ppds_pkg::D_W+1:0] : cand[ppds_pkg::D_W+1:0];
        n_root   = {r_root[ppds_pkg::D_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_val  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[ppds_pkg::V_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_step <= r_step + 1'b1;
                if (r_step == ppds_pkg::ROOT_STEP_W'(ppds_pkg::D_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: src/ppds_div.sv
`default_nettype none

module ppds_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ppds_pkg::ACC_W-1:0] i_dividend,
    input  wire logic [ppds_pkg::CNT_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ppds_pkg::ACC_W-1:0]      o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [ppds_pkg::DIV_STEP_W-1:0]  r_step;
    logic [ppds_pkg::ACC_W-1:0]       r_q;
    logic [ppds_pkg::CNT_W-1:0]       r_rem;
    logic [ppds_pkg::CNT_W-1:0]       r_den;

    logic [ppds_pkg::CNT_W:0]         cand;
    logic [ppds_pkg::CNT_W:0]         cand_sub;
    logic                             ge;
    logic [ppds_pkg::CNT_W-1:0]       n_rem;

    always_comb begin
        cand     = {r_rem, r_q[ppds_pkg::ACC_W-1]};
        ge       = (cand >= {1'b0, r_den});
        cand_sub = cand - {1'b0, r_den};
        n_rem    = ge ? cand_sub[ppds_pkg::CNT_W-1:0] : cand[ppds_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_q    <= {r_q[ppds_pkg::ACC_W-2:0], ge};
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == ppds_pkg::DIV_STEP_W'(ppds_pkg::ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire
